[rtl/core/generational_slot_pool_assert.svh]
// Assertion macros used by the generational slot pool controller.
`ifndef GENERATIONAL_SLOT_POOL_ASSERT_SVH
`define GENERATIONAL_SLOT_POOL_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define GSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gsp_pkg.sv]
// Shared types and codes of the generational slot pool.
package gsp_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;

    localparam t_kind KIND_ACQUIRE  = 2'd0;
    localparam t_kind KIND_RELEASE  = 2'd1;
    localparam t_kind KIND_GENERATE = 2'd2;
    localparam t_kind KIND_DECODE   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_BAD   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request, launch memory reads
        logic commit;   // update state, load the result register
    } t_cmd;

endpackage

[rtl/core/gsp_ram.sv]
// Generic simple dual-port RAM with registered read.
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/gsp_ctrl.sv]
// Controller of the generational slot pool: request sequencing and result handshake.
`include "generational_slot_pool_assert.svh"

module gsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gsp_pkg::t_cmd o_cmd
);
    import gsp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept, w_commit;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    // Finish only when the result register is free or being emptied.
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = w_accept;
    assign o_cmd.commit  = w_commit;

    `GSP_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC, "accept did not enter execute")
    `GSP_ASSERT_NEXT(a_commit_to_valid, i_clk, i_rst_n, w_commit, r_out_valid, "commit did not raise result valid")
    `GSP_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, w_commit, !w_accept, "capture and commit together")

endmodule

[rtl/core/gsp_dpath.sv]
// Datapath of the generational slot pool: free stack, generation counters, result register.
module gsp_dpath #(
    parameter int NUM_SLOTS = 255,
    parameter int SLOT_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsp_pkg::t_cmd     i_cmd,
    input  gsp_pkg::t_kind    i_kind,
    input  logic [7:0]        i_slot,
    input  logic [31:0]       i_handle_in,
    output logic [7:0]        o_slot_out,
    output logic [31:0]       o_handle_out,
    output gsp_pkg::t_status  o_status
);
    import gsp_pkg::*;

    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int GEN_DEPTH = (NUM_SLOTS + 1 > 256) ? 256 : NUM_SLOTS + 1;
    localparam int GAW       = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
    localparam int GEN_W     = 32 - SLOT_BITS;

    // Request registers.
    t_kind            r_kind;
    logic [7:0]       r_slot;
    logic [7:0]       r_dec;

    // Stack control: count and lowest count reached since reset.
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_low, n_low;
    logic [GEN_DEPTH-1:0] r_gen_vld, n_gen_vld;

    // Result registers.
    logic [7:0]       r_slot_out, n_slot_out;
    logic [31:0]      r_handle_out, n_handle_out;
    t_status          r_status, n_status;

    logic [CNT_W-1:0] w_pop_idx;
    logic [15:0]      w_init_val;
    logic [7:0]       w_stack_rdata, w_top;
    logic [GEN_W-1:0] w_gen_rdata, w_gen_cur, w_gen_next;
    logic [15:0]      w_slot_ext, w_dec_ext;
    logic             w_slot_ok;
    logic             w_push_we, w_gen_we;

    assign w_pop_idx  = r_count - CNT_W'(1);
    assign w_dec_ext  = 16'(i_handle_in[SLOT_BITS-1:0]);
    assign w_slot_ext = 16'(r_slot);

    gsp_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_push_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_slot),
        .i_re    (i_cmd.capture),
        .i_raddr (w_pop_idx[IDX_W-1:0]),
        .o_rdata (w_stack_rdata)
    );

    gsp_ram #(.WIDTH(GEN_W), .DEPTH(GEN_DEPTH)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (w_gen_we),
        .i_waddr (r_slot[GAW-1:0]),
        .i_wdata (w_gen_next),
        .i_re    (i_cmd.capture),
        .i_raddr (i_slot[GAW-1:0]),
        .o_rdata (w_gen_rdata)
    );

    // Entries below the low mark still hold their reset contents.
    assign w_init_val = 16'(NUM_SLOTS) - 16'(w_pop_idx);
    assign w_top      = (r_count > r_low) ? w_stack_rdata : w_init_val[7:0];

    assign w_gen_cur  = r_gen_vld[r_slot[GAW-1:0]] ? w_gen_rdata : '0;
    assign w_gen_next = w_gen_cur + GEN_W'(1);

    assign w_slot_ok  = (r_slot != 8'd0) && (17'(r_slot) <= 17'(NUM_SLOTS));
    assign w_push_we  = i_cmd.commit && (r_kind == KIND_RELEASE) && w_slot_ok &&
                        (r_count < CNT_W'(NUM_SLOTS));
    assign w_gen_we   = i_cmd.commit && (r_kind == KIND_GENERATE) && w_slot_ok;

    always_comb begin
        n_count      = r_count;
        n_low        = r_low;
        n_gen_vld    = r_gen_vld;
        n_slot_out   = r_slot_out;
        n_handle_out = r_handle_out;
        n_status     = r_status;
        if (i_cmd.commit) begin
            n_slot_out   = 8'd0;
            n_handle_out = 32'd0;
            n_status     = ST_OK;
            unique case (r_kind)
                KIND_ACQUIRE: begin
                    if (r_count != '0) begin
                        n_count    = w_pop_idx;
                        n_slot_out = w_top;
                        if (w_pop_idx < r_low) begin
                            n_low = w_pop_idx;
                        end
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                KIND_RELEASE: begin
                    if (w_push_we) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_status = ST_BAD;
                    end
                end
                KIND_GENERATE: begin
                    if (w_slot_ok) begin
                        n_gen_vld[r_slot[GAW-1:0]] = 1'b1;
                        n_slot_out   = r_slot;
                        n_handle_out = {w_gen_next, w_slot_ext[SLOT_BITS-1:0]};
                    end else begin
                        n_status = ST_BAD;
                    end
                end
                KIND_DECODE: begin
                    n_slot_out = r_dec;
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CNT_W'(NUM_SLOTS);
            r_low     <= CNT_W'(NUM_SLOTS);
            r_gen_vld <= '0;
        end else begin
            r_count   <= n_count;
            r_low     <= n_low;
            r_gen_vld <= n_gen_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_slot <= i_slot;
            r_dec  <= w_dec_ext[7:0];
        end
        r_slot_out   <= n_slot_out;
        r_handle_out <= n_handle_out;
        r_status     <= n_status;
    end

    assign o_slot_out   = r_slot_out;
    assign o_handle_out = r_handle_out;
    assign o_status     = r_status;

endmodule

[rtl/core/generational_slot_pool.sv]
// Top level of the generational slot pool: slot allocator with per-slot generations.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request transaction:
//   i_kind selects acquire, release, generate handle or decode handle, with
//   i_slot and i_handle_in as operands. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result transaction per request:
//   o_slot_out, o_handle_out and o_status.
//   An accepted request is captured and then committed; no new request is
//   taken before the commit. Capture reads the free stack and the generation
//   memory (registered read); commit does the pop, push or counter update and
//   loads the result register and raises the result valid.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its commit holds until the receiver takes the
//   pending result, so a stalled receiver stalls the pool after one request.
//   Reset: the free stack holds every slot with slot 1 on top and all
//   generations read as zero. No clearing pass: a low-water mark covers the
//   stack and valid bits cover the generation memory, so the pool is ready
//   as soon as reset is released.
module generational_slot_pool #(
    parameter int NUM_SLOTS = 255,
    parameter int SLOT_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gsp_pkg::t_kind   i_kind,
    input  logic [7:0]       i_slot,
    input  logic [31:0]      i_handle_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_slot_out,
    output logic [31:0]      o_handle_out,
    output gsp_pkg::t_status o_status
);
    import gsp_pkg::*;

    // Capture and commit strobes from the sequencer.
    t_cmd w_cmd;

    // Sequence each request and own the result handshake.
    gsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Hold the free stack, generation counters and result register.
    gsp_dpath #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_BITS (SLOT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_handle_in  (i_handle_in),
        .o_slot_out   (o_slot_out),
        .o_handle_out (o_handle_out),
        .o_status     (o_status)
    );

endmodule

[dv/generational_slot_pool_checker.sv]
// Checker for the generational slot pool: predicts each reply and compares it at the output.
module generational_slot_pool_checker #(
    parameter int NUM_SLOTS = 255,
    parameter int SLOT_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  gsp_pkg::t_kind   i_kind,
    input  logic [7:0]       i_slot,
    input  logic [31:0]      i_handle_in,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_slot_out,
    input  logic [31:0]      i_handle_out,
    input  gsp_pkg::t_status i_status,
    output int               o_fail_count,
    output int               o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import gsp_pkg::*;

    localparam int GEN_BITS = 32 - SLOT_BITS;
    localparam logic [31:0] SLOT_MASK = (32'd1 << SLOT_BITS) - 32'd1;

    typedef struct packed {
        logic [7:0]  slot;
        logic [31:0] handle;
        t_status     status;
    } t_pool_reply;

    t_pool_reply         owed_replies[$];
    logic [7:0]          free_slots[NUM_SLOTS];
    int unsigned         free_count;
    logic [GEN_BITS-1:0] slot_gen[NUM_SLOTS+1];
    int                  fails;

    // Mirror of the pool: pop, push, generation bump or slot extraction.
    function automatic t_pool_reply apply_pool_op(t_kind op, logic [7:0] slot,
                                                  logic [31:0] handle);
        t_pool_reply         r;
        logic [GEN_BITS-1:0] g;
        logic                slot_ok;
        r       = '0;
        r.status = ST_OK;
        slot_ok = (slot != 8'd0) && (int'(slot) <= NUM_SLOTS);
        case (op)
            KIND_ACQUIRE: begin
                if (free_count > 0) begin
                    free_count--;
                    r.slot = free_slots[free_count];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            KIND_RELEASE: begin
                if (!slot_ok || free_count >= NUM_SLOTS) begin
                    r.status = ST_BAD;
                end else begin
                    free_slots[free_count] = slot;
                    free_count++;
                end
            end
            KIND_GENERATE: begin
                if (!slot_ok) begin
                    r.status = ST_BAD;
                end else begin
                    g             = slot_gen[slot] + 1'b1;
                    slot_gen[slot] = g;
                    r.handle      = (32'(g) << SLOT_BITS) | (32'(slot) & SLOT_MASK);
                    r.slot        = slot;
                end
            end
            default: begin
                r.slot = 8'(handle & SLOT_MASK);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pool_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                free_slots[i] = 8'(NUM_SLOTS - i);
            end
            for (int i = 0; i <= NUM_SLOTS; i++) begin
                slot_gen[i] = '0;
            end
            free_count = NUM_SLOTS;
            owed_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_replies.size() == 0) begin
                    $display("%0t: reply with none owed: slot %0d handle 0x%08h status %0d",
                             $time, i_slot_out, i_handle_out, i_status);
                    fails++;
                end else begin
                    want = owed_replies.pop_front();
                    if (i_slot_out !== want.slot) begin
                        $display("%0t: slot_out expected %0d actual %0d",
                                 $time, want.slot, i_slot_out);
                        fails++;
                    end
                    if (i_handle_out !== want.handle) begin
                        $display("%0t: handle_out expected 0x%08h actual 0x%08h",
                                 $time, want.handle, i_handle_out);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_replies.push_back(apply_pool_op(i_kind, i_slot, i_handle_in));
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_replies.size();
    end

endmodule

[dv/generational_slot_pool_tb.sv]
// Testbench top for the generational slot pool: stimulus, receiver stalls and verdict.
module generational_slot_pool_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gsp_pkg::*;

    localparam int NUM_SLOTS = 255;
    localparam int SLOT_BITS = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_kind       in_kind = KIND_ACQUIRE;
    logic [7:0]  in_slot = 8'd0;
    logic [31:0] in_handle = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  slot_out;
    logic [31:0] handle_out;
    t_status     status;
    int          fail_count;
    int          pending;

    // Sender pacing: items left in the current burst.
    int          burst_left = 0;
    int          random_sent = 0;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit          hold_off_request = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    generational_slot_pool #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_BITS (SLOT_BITS)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_slot       (in_slot),
        .i_handle_in  (in_handle),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_slot_out   (slot_out),
        .o_handle_out (handle_out),
        .o_status     (status)
    );

    generational_slot_pool_checker #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_BITS (SLOT_BITS)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_slot       (in_slot),
        .i_handle_in  (in_handle),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_slot_out   (slot_out),
        .i_handle_out (handle_out),
        .i_status     (status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one request transaction and hold it until the pool takes it.
    // Called right after a rising edge; returns at the edge of acceptance.
    task automatic send_request(input t_kind op, input logic [7:0] slot,
                                input logic [31:0] handle);
        in_valid  <= 1'b1;
        in_kind   <= op;
        in_slot   <= slot;
        in_handle <= handle;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Advance the burst; at its end drop valid for a random gap and open a new one.
    // About one burst in five, picked at random, is long so stretches without idling occur.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and hold until every owed reply has come back.
    task automatic drain_pool();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly valid slot numbers, now and then any 8-bit value (slot 0 included).
    function automatic logic [7:0] pick_slot();
        if ($urandom_range(0, 15) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(1, NUM_SLOTS));
    endfunction

    task automatic send_random(input t_kind op, input logic [7:0] slot);
        send_request(op, slot, $urandom);
        random_sent++;
        pace_sender();
    endtask

    // Receiver: stall pattern of its own, switching mode after each randomly sized span.
    initial begin
        int         mode;
        int         span_left;
        logic [7:0] pattern;
        mode = 0;
        span_left = 0;
        pattern = 8'b1011_0110;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (span_left == 0) begin
                mode = $urandom_range(0, 3);
                span_left = $urandom_range(32, 256);
            end
            span_left--;
            if (hold_off_request) begin
                // Long hold-off: the pool fills and must stall its input.
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: begin
                        out_ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    default: out_ready <= ($urandom_range(0, 99) < 85);
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int         seg;
        int         len;
        int         pick;
        logic [7:0] hot_slot;
        bit         hold_done;
        bit         first_seg;
        hold_done = 1'b0;
        first_seg = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: edges of every field and the named corner cases.
        send_request(KIND_RELEASE,  8'd7,   32'd0);         // stack full: flagged
        send_request(KIND_RELEASE,  8'd0,   32'd0);         // invalid slot
        send_request(KIND_GENERATE, 8'd0,   32'hFFFF_FFFF); // invalid slot, no bump
        send_request(KIND_ACQUIRE,  8'hFF,  32'hFFFF_FFFF); // pops slot 1
        send_request(KIND_ACQUIRE,  8'd0,   32'd0);         // pops slot 2
        send_request(KIND_GENERATE, 8'd1,   32'd0);
        send_request(KIND_GENERATE, 8'd1,   32'd0);
        send_request(KIND_GENERATE, 8'(NUM_SLOTS), 32'd0);  // highest slot
        send_request(KIND_RELEASE,  8'd0,   32'd0);         // invalid, stack not full
        send_request(KIND_RELEASE,  8'd2,   32'd0);
        send_request(KIND_ACQUIRE,  8'd0,   32'd0);         // LIFO: slot 2 again
        send_request(KIND_DECODE,   8'd0,   32'h0000_0000);
        send_request(KIND_DECODE,   8'hFF,  32'hFFFF_FFFF);
        send_request(KIND_DECODE,   8'd0,   32'h0000_0100); // decodes to slot 0, still ok
        send_request(KIND_DECODE,   8'h55,  32'hA5A5_A55A);
        send_request(KIND_GENERATE, 8'd128, 32'h8000_0000);
        send_request(KIND_RELEASE,  8'(NUM_SLOTS), 32'd0);
        send_request(KIND_RELEASE,  8'd1,   32'd0);
        send_request(KIND_RELEASE,  8'd2,   32'd0);
        send_request(KIND_GENERATE, 8'd1,   32'd0);
        send_request(KIND_ACQUIRE,  8'd0,   32'd0);
        pace_sender();

        // Random part, built from segments of well-formed runs and noise.
        while (random_sent < RANDOM_ITEMS) begin
            if (!hold_done && random_sent >= RANDOM_ITEMS / 2) begin
                // Keep offering while the receiver holds off, then let it all drain.
                hold_done = 1'b1;
                hold_off_request = 1'b1;
                repeat (30) begin
                    send_request(t_kind'($urandom_range(0, 3)), pick_slot(), $urandom);
                end
                drain_pool();
            end
            // Open with a long acquire run so the empty stack can be reached early.
            seg = first_seg ? 0 : $urandom_range(0, 9);
            first_seg = 1'b0;
            case (seg)
                0, 1: begin
                    len = $urandom_range(16, 280);
                    repeat (len) send_random(KIND_ACQUIRE, 8'($urandom_range(0, 255)));
                end
                2, 3: begin
                    len = $urandom_range(16, 280);
                    repeat (len) send_random(KIND_RELEASE, pick_slot());
                end
                8: begin
                    // Hammer one slot's generation, with an odd other request.
                    hot_slot = pick_slot();
                    len = $urandom_range(8, 40);
                    repeat (len) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_random(t_kind'($urandom_range(0, 3)), pick_slot());
                        end else begin
                            send_random(KIND_GENERATE, hot_slot);
                        end
                    end
                end
                9: begin
                    len = $urandom_range(4, 32);
                    repeat (len) begin
                        send_random(t_kind'($urandom_range(0, 3)),
                                    8'($urandom_range(0, 255)));
                    end
                end
                default: begin
                    // Mixed traffic weighted toward allocate and free.
                    len = $urandom_range(8, 64);
                    repeat (len) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 30) begin
                            send_random(KIND_ACQUIRE, pick_slot());
                        end else if (pick < 60) begin
                            send_random(KIND_RELEASE, pick_slot());
                        end else if (pick < 85) begin
                            send_random(KIND_GENERATE, pick_slot());
                        end else begin
                            send_random(KIND_DECODE, pick_slot());
                        end
                    end
                end
            endcase
        end

        // Wind down: wait for every owed reply, then give the verdict.
        drain_pool();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/gsp_pkg.sv
rtl/core/gsp_ram.sv
rtl/core/gsp_ctrl.sv
rtl/core/gsp_dpath.sv
rtl/core/generational_slot_pool.sv
dv/generational_slot_pool_checker.sv
dv/generational_slot_pool_tb.sv
